/* hdl/fura_pkg.sv */
// Shared widths, status codes and controller/datapath interface types.
package fura_pkg;

  localparam int BYTES_W  = 21;
  localparam int ALIGN_W  = 17;
  localparam int FENCE_W  = 64;
  localparam int OFFSET_W = 20;
  localparam int LIVE_W   = 5;
  localparam int CAND_W   = 23;

  typedef enum logic [2:0] {
    ST_GRANTED     = 3'd0,
    ST_RETIRE_ONLY = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_NO_ROOM     = 3'd3,
    ST_TABLE_FULL  = 3'd4
  } status_t;

  typedef struct packed {
    logic    load;
    logic    rd_oldest;
    logic    rd_scan;
    logic    pop;
    logic    wrap;
    logic    div_start;
    logic    idx_clr;
    logic    idx_inc;
    logic    cand_head;
    logic    cand_zero;
    logic    grant;
    logic    set_status;
    status_t status_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic table_full;
    logic n_zero;
    logic too_large;
    logic fence_le;
    logic scan_end;
    logic fits_cap;
    logic overlap;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

/* hdl/fura_div.sv */
// Bit-serial remainder unit: one restoring step per cycle.
module fura_div #(
  parameter int DVD_W = 21,
  parameter int DIV_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r;
  logic [DIV_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   trial;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      dvd_r  <= dividend;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* hdl/fura_dp.sv */
// Datapath: region table memory, head, counters, candidate checks and result register.
module fura_dp #(
  parameter int MAX_REGIONS    = 16,
  parameter int MAX_RING_BYTES = 1048576
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fura_pkg::BYTES_W-1:0]   cfg_wdata,
  input  logic [fura_pkg::BYTES_W-1:0]   in_request_bytes,
  input  logic [fura_pkg::ALIGN_W-1:0]   in_alignment,
  input  logic [fura_pkg::FENCE_W-1:0]   in_fence_value,
  input  logic [fura_pkg::FENCE_W-1:0]   in_completed_fence,
  input  fura_pkg::cmd_t                 cmd,
  output fura_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [fura_pkg::OFFSET_W-1:0]  out_grant_offset,
  output logic [fura_pkg::LIVE_W-1:0]    out_live_regions,
  output logic [fura_pkg::BYTES_W-1:0]   out_live_bytes
);

  localparam int IW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW  = $clog2(MAX_REGIONS + 1);
  localparam int SW  = ((IW > CW) ? IW : CW) + 1;
  localparam int BW  = fura_pkg::BYTES_W;
  localparam int AW  = fura_pkg::ALIGN_W;
  localparam int FW  = fura_pkg::FENCE_W;
  localparam int KW  = fura_pkg::CAND_W;
  localparam logic [24:0] MAX_BYTES = 25'(MAX_RING_BYTES);

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(MAX_REGIONS)) begin
      s = s - SW'(MAX_REGIONS);
    end
    return s[IW-1:0];
  endfunction

  logic [BW-1:0] start_mem [MAX_REGIONS];
  logic [BW-1:0] len_mem   [MAX_REGIONS];
  logic [FW-1:0] fence_mem [MAX_REGIONS];

  logic [BW-1:0]             cap_r, head_r, total_r;
  logic [IW-1:0]             oldest_r;
  logic [CW-1:0]             count_r, idx_r;
  logic [BW-1:0]             n_r;
  logic [AW-1:0]             align_r;
  logic [FW-1:0]             fence_r, done_r;
  logic [KW-1:0]             cand_r;
  fura_pkg::status_t         status_r;
  logic [fura_pkg::OFFSET_W-1:0] offset_r;
  logic [BW-1:0]             rd_start_r, rd_len_r;
  logic [FW-1:0]             rd_fence_r;
  logic                      out_valid_r;
  logic [2:0]                out_status_r;
  logic [fura_pkg::OFFSET_W-1:0] out_offset_r;
  logic [fura_pkg::LIVE_W-1:0]   out_regions_r;
  logic [BW-1:0]             out_bytes_r;

  logic [IW-1:0] rd_addr, wr_addr;
  logic [BW-1:0] cfg_cap;
  logic          div_done;
  logic [AW-1:0] div_rem;
  logic [KW-1:0] cand_end, rd_end, head_round;

  fura_div #(.DVD_W(BW), .DIV_W(AW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (head_r),
    .divisor   (align_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    rd_addr  = cmd.rd_oldest ? oldest_r : slot_of(oldest_r, idx_r);
    wr_addr  = slot_of(oldest_r, count_r);
    cfg_cap  = (25'(cfg_wdata) > MAX_BYTES) ? MAX_BYTES[BW-1:0] : cfg_wdata;
    cand_end = cand_r + KW'(n_r);
    rd_end   = KW'(rd_start_r) + KW'(rd_len_r);
    // Rounding up needs no adjustment when the alignment is trivial or already met.
    if (align_r <= AW'(1) || div_rem == '0) begin
      head_round = KW'(head_r);
    end else begin
      head_round = KW'(head_r) + KW'(align_r) - KW'(div_rem);
    end

    sts.count_zero = (count_r == '0);
    sts.table_full = (count_r >= CW'(MAX_REGIONS));
    sts.n_zero     = (n_r == '0);
    sts.too_large  = (n_r > cap_r);
    sts.fence_le   = (rd_fence_r <= done_r);
    sts.scan_end   = (idx_r == count_r);
    sts.fits_cap   = (cand_end <= KW'(cap_r));
    sts.overlap    = (cand_r < rd_end) && (KW'(rd_start_r) < cand_end);
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_oldest || cmd.rd_scan) begin
      rd_start_r <= start_mem[rd_addr];
      rd_len_r   <= len_mem[rd_addr];
      rd_fence_r <= fence_mem[rd_addr];
    end
    if (cmd.grant) begin
      start_mem[wr_addr] <= cand_r[BW-1:0];
      len_mem[wr_addr]   <= n_r;
      fence_mem[wr_addr] <= fence_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r     <= in_request_bytes;
      align_r <= in_alignment;
      fence_r <= in_fence_value;
      done_r  <= in_completed_fence;
    end
    if (cmd.cand_head) begin
      cand_r <= head_round;
    end else if (cmd.cand_zero) begin
      cand_r <= '0;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.grant) begin
      status_r <= fura_pkg::ST_GRANTED;
      offset_r <= cand_r[fura_pkg::OFFSET_W-1:0];
    end else if (cmd.set_status) begin
      status_r <= cmd.status_code;
      offset_r <= '0;
    end
    if (cmd.out_load) begin
      out_status_r  <= status_r;
      out_offset_r  <= offset_r;
      out_regions_r <= fura_pkg::LIVE_W'(count_r);
      out_bytes_r   <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= BW'(65536);
      head_r      <= '0;
      total_r     <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        // A capacity write restarts the ring from empty.
        cap_r    <= cfg_cap;
        head_r   <= '0;
        total_r  <= '0;
        oldest_r <= '0;
        count_r  <= '0;
      end else if (cmd.pop) begin
        oldest_r <= slot_of(oldest_r, CW'(1));
        count_r  <= count_r - 1'b1;
        total_r  <= total_r - rd_len_r;
      end else if (cmd.wrap) begin
        if (count_r == '0 && head_r == cap_r) begin
          head_r <= '0;
        end
      end else if (cmd.grant) begin
        count_r <= count_r + 1'b1;
        head_r  <= cand_end[BW-1:0];
        total_r <= total_r + n_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_grant_offset = out_offset_r;
  assign out_live_regions = out_regions_r;
  assign out_live_bytes   = out_bytes_r;

endmodule

/* hdl/fura_ctl.sv */
// Controller: sequences retire walk, rounding, overlap scans and the grant.
module fura_ctl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fura_pkg::sts_t sts,
  output fura_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RET_CHK, S_RET_EV, S_WRAP, S_CLASS, S_DIV,
    S_CHK, S_CHK_EV, S_FAIL, S_GRANT, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    second_nxt  = second_r;
    in_ready    = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RET_CHK;
        end
      end
      S_RET_CHK: begin
        if (sts.count_zero) begin
          state_nxt = S_WRAP;
        end else begin
          cmd.rd_oldest = 1'b1;
          state_nxt     = S_RET_EV;
        end
      end
      S_RET_EV: begin
        if (sts.fence_le) begin
          cmd.pop   = 1'b1;
          state_nxt = S_RET_CHK;
        end else begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        priority if (sts.n_zero) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = fura_pkg::ST_RETIRE_ONLY;
          state_nxt       = S_FINISH;
        end else if (sts.too_large) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = fura_pkg::ST_TOO_LARGE;
          state_nxt       = S_FINISH;
        end else if (sts.table_full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = fura_pkg::ST_TABLE_FULL;
          state_nxt       = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          second_nxt    = 1'b0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.cand_head = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        priority if (!sts.fits_cap) begin
          state_nxt = S_FAIL;
        end else if (sts.scan_end) begin
          state_nxt = S_GRANT;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_CHK_EV;
        end
      end
      S_CHK_EV: begin
        if (sts.overlap) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_FAIL: begin
        // The second try is at offset zero, which every alignment accepts.
        if (!second_r) begin
          second_nxt    = 1'b1;
          cmd.cand_zero = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_nxt     = S_CHK;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = fura_pkg::ST_NO_ROOM;
          state_nxt       = S_FINISH;
        end
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

/* hdl/fenced_upload_ring_allocator.sv */
// Fenced upload ring allocator: top level joining controller and datapath.
// Each request first retires, oldest first, the regions whose fence value is at most the
// completed fence, and the retire walk stops at a region that is still in flight. The head
// is then rounded up to the alignment, and each placement try reads the live regions one
// by one through the single read port of the region table to check them for overlap. A
// retire-only, too-large or table-full request skips the rounding and the scans. The
// 21-step bit-serial remainder unit does the rounding. A new request is taken once the
// previous result is in the output register.
module fenced_upload_ring_allocator #(
  parameter int MAX_REGIONS    = 16,
  parameter int MAX_RING_BYTES = 1048576
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fura_pkg::BYTES_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fura_pkg::BYTES_W-1:0]        in_request_bytes,
  input  logic [fura_pkg::ALIGN_W-1:0]        in_alignment,
  input  logic [fura_pkg::FENCE_W-1:0]        in_fence_value,
  input  logic [fura_pkg::FENCE_W-1:0]        in_completed_fence,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_status,
  output logic [fura_pkg::OFFSET_W-1:0]       out_grant_offset,
  output logic [fura_pkg::LIVE_W-1:0]         out_live_regions,
  output logic [fura_pkg::BYTES_W-1:0]        out_live_bytes
);

  fura_pkg::cmd_t cmd;
  fura_pkg::sts_t sts;

  fura_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fura_dp #(
    .MAX_REGIONS    (MAX_REGIONS),
    .MAX_RING_BYTES (MAX_RING_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_request_bytes   (in_request_bytes),
    .in_alignment       (in_alignment),
    .in_fence_value     (in_fence_value),
    .in_completed_fence (in_completed_fence),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_grant_offset   (out_grant_offset),
    .out_live_regions   (out_live_regions),
    .out_live_bytes     (out_live_bytes)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while a previous one is in progress");

  a_no_offset_unless_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != fura_pkg::ST_GRANTED) |-> (out_grant_offset == '0))
    else $error("nonzero offset on a request that was not granted");

  a_granted_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == fura_pkg::ST_GRANTED) |-> (out_live_bytes != '0))
    else $error("granted request leaves no bytes in flight");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.count_zero)
    else $error("retire issued on an empty region table");

endmodule
